>>> rtl/core/glf_pkg.sv
// Shared types and constants for the multibyte glyph locator.
// Used by every module of the block; no dependencies.
package glf_pkg;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_SJIS   = 2'd1,
    MODE_EUC    = 2'd2,
    MODE_GB     = 2'd3
  } glf_mode_e;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0]  STRIDE_NORMAL = 2'd1;
  localparam logic [1:0]  STRIDE_HALVES = 2'd2;
  localparam logic [19:0] NATIONAL_BASE = 20'd4096;
  localparam logic [19:0] STEP_NORMAL   = 20'd16;
  localparam logic [19:0] STEP_HALVES   = 20'd1;
  localparam logic [13:0] HALF_WIDTH    = 14'd8;

  // one queued draw job: a single glyph or a double-byte pair
  typedef struct packed {
    logic        is_pair;
    logic        font_table;
    logic        interleave;
    logic [14:0] cell_idx;
    logic [7:0]  code;
    logic [13:0] pen;
  } glf_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } glf_qstat_t;

endpackage

>>> rtl/core/glf_in_if.sv
// Input byte channel: valid/ready plus text byte payload.
// Depends on nothing.
interface glf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code_byte;
  logic        first_of_string;
  logic [11:0] start_x;

  modport source (output valid, code_byte, first_of_string, start_x, input ready);
  modport sink   (input valid, code_byte, first_of_string, start_x, output ready);
endinterface

>>> rtl/core/glf_out_if.sv
// Output glyph command channel: valid/ready plus draw command payload.
// Depends on nothing.
interface glf_out_if;
  logic               valid;
  logic               ready;
  logic               font_table;
  logic [19:0]        glyph_offset;
  logic signed [13:0] draw_x;
  logic [1:0]         row_stride;
  logic               last_glyph;

  modport source (output valid, font_table, glyph_offset, draw_x, row_stride, last_glyph,
                  input ready);
  modport sink   (input valid, font_table, glyph_offset, draw_x, row_stride, last_glyph,
                  output ready);
endinterface

>>> rtl/core/glf_front.sv
// Front end: accepts text beats, tracks pen and lead byte, classifies codes.
// Depends on glf_pkg and glf_in_if.
module glf_front
  import glf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  glf_mode_e   mode_i,
  glf_in_if.sink      text_i,
  input  glf_qstat_t  qstat_i,
  output logic        push_o,
  output glf_op_t     op_o
);

  logic [7:0]  lead_q, lead_d;
  logic [13:0] pen_q, pen_d;
  logic [13:0] pen_cur;
  logic        accept;
  logic        emit;
  logic [7:0]  b;
  logic [14:0] k_base, k_adj, t_val, prod;
  logic        k_inc;

  assign b       = text_i.code_byte;
  assign accept  = text_i.valid && text_i.ready;
  assign pen_cur = text_i.first_of_string ? {2'b00, text_i.start_x} : pen_q;
  assign text_i.ready = !qstat_i.full;

  always_comb begin
    k_base = 15'd0;
    t_val  = 15'd0;
    k_inc  = 1'b0;
    if (mode_i == MODE_SJIS) begin
      if (lead_q inside {[8'h81:8'h9f]}) begin
        k_base = 15'({7'd0, lead_q} - 15'h81) << 1;
      end else begin
        k_base = 15'((15'({7'd0, lead_q} - 15'he0) << 1) + 15'd62);
      end
      if (b inside {[8'h40:8'h7e]}) begin
        t_val = 15'({7'd0, b} - 15'h40);
      end else if (b inside {[8'h80:8'h9e]}) begin
        t_val = 15'({7'd0, b} - 15'h80 + 15'd63);
      end else begin
        t_val = 15'({7'd0, b} - 15'h9f);
        k_inc = 1'b1;
      end
    end else begin
      k_base = 15'({7'd0, lead_q} - 15'ha1);
      t_val  = 15'({7'd0, b} - 15'ha1);
    end
  end

  assign k_adj = k_base + {14'd0, k_inc};
  assign prod  = 15'(k_adj * 15'd94);

  always_comb begin
    lead_d        = lead_q;
    emit          = 1'b1;
    op_o.is_pair    = 1'b0;
    op_o.font_table = 1'b1;
    op_o.interleave = 1'b0;
    op_o.cell_idx   = prod + t_val;
    op_o.code       = b;
    op_o.pen        = pen_cur;
    case (mode_i)
      MODE_SINGLE: begin
        op_o.font_table = 1'b0;
      end
      MODE_SJIS, MODE_EUC: begin
        if (lead_q == 8'd0) begin
          if ((mode_i == MODE_SJIS && (b inside {[8'h81:8'h9f], [8'he0:8'hfc]})) ||
              (mode_i == MODE_EUC && (b inside {[8'h81:8'hfe]}))) begin
            lead_d = b;
            emit   = 1'b0;
          end
        end else begin
          lead_d       = 8'd0;
          op_o.is_pair = 1'b1;
        end
      end
      MODE_GB: begin
        if (lead_q == 8'd0) begin
          if (b >= 8'ha0) begin
            lead_d = b;
            emit   = 1'b0;
          end else begin
            op_o.font_table = 1'b0;
          end
        end else begin
          lead_d          = 8'd0;
          op_o.is_pair    = 1'b1;
          op_o.interleave = 1'b1;
        end
      end
      default: begin
        op_o.font_table = 1'b0;
      end
    endcase
  end

  assign pen_d  = pen_cur + HALF_WIDTH;
  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 8'd0;
      pen_q  <= 14'd0;
    end else if (accept) begin
      lead_q <= lead_d;
      pen_q  <= pen_d;
    end
  end

endmodule

>>> rtl/core/glf_queue.sv
// Short job queue between front and back ends.
// Depends on glf_pkg.
module glf_queue
  import glf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  glf_op_t    op_i,
  input  logic       pop_i,
  output glf_op_t    op_o,
  output glf_qstat_t stat_o
);

  glf_op_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign op_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/core/glf_back.sv
// Back end: turns queued jobs into one or two glyph command beats.
// Depends on glf_pkg and glf_out_if.
module glf_back
  import glf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  glf_op_t    op_i,
  input  glf_qstat_t qstat_i,
  output logic       pop_o,
  glf_out_if.source  glyph_o
);

  logic        valid_q;
  logic        table_q;
  logic [19:0] off_q;
  logic [13:0] x_q;
  logic [1:0]  stride_q;
  logic        last_q;

  logic        second_q;
  logic [19:0] off2_q;
  logic [13:0] x2_q;
  logic [1:0]  stride2_q;

  logic        load;
  logic [19:0] off0, off1;

  assign load  = !valid_q || glyph_o.ready;
  assign pop_o = load && !second_q && !qstat_i.empty;

  assign off0 = {op_i.cell_idx, 5'd0} + (op_i.interleave ? 20'd0 : NATIONAL_BASE);
  assign off1 = off0 + (op_i.interleave ? STEP_HALVES : STEP_NORMAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      if (second_q) begin
        valid_q  <= 1'b1;
        second_q <= 1'b0;
      end else if (!qstat_i.empty) begin
        valid_q  <= 1'b1;
        second_q <= op_i.is_pair;
      end else begin
        valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (second_q) begin
        table_q  <= 1'b1;
        off_q    <= off2_q;
        x_q      <= x2_q;
        stride_q <= stride2_q;
        last_q   <= 1'b1;
      end else if (!qstat_i.empty) begin
        if (op_i.is_pair) begin
          table_q   <= 1'b1;
          off_q     <= off0;
          x_q       <= op_i.pen - HALF_WIDTH;
          stride_q  <= op_i.interleave ? STRIDE_HALVES : STRIDE_NORMAL;
          last_q    <= 1'b0;
          off2_q    <= off1;
          x2_q      <= op_i.pen;
          stride2_q <= op_i.interleave ? STRIDE_HALVES : STRIDE_NORMAL;
        end else begin
          table_q  <= op_i.font_table;
          off_q    <= {8'd0, op_i.code, 4'd0};
          x_q      <= op_i.pen;
          stride_q <= STRIDE_NORMAL;
          last_q   <= 1'b1;
        end
      end
    end
  end

  assign glyph_o.valid        = valid_q;
  assign glyph_o.font_table   = table_q;
  assign glyph_o.glyph_offset = off_q;
  assign glyph_o.draw_x       = $signed(x_q);
  assign glyph_o.row_stride   = stride_q;
  assign glyph_o.last_glyph   = last_q;

endmodule

>>> rtl/core/multibyte_text_glyph_locator.sv
// Multibyte text glyph locator: text bytes in, glyph draw commands out.
// An accepted byte passes the queue, then the output register. Input takes one byte per
// cycle while the queue is not full; the output register gives one beat per cycle while
// ready is high; a double-byte glyph gives two beats, a single one; lead bytes none.
// Reset: asynchronous active-low; clears mode, lead byte, pen, queue and output valid.
module multibyte_text_glyph_locator
  import glf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       text_mode_we_i,
  input  logic [1:0] text_mode_i,
  glf_in_if.sink     text_i,
  glf_out_if.source  glyph_o
);

  glf_mode_e  mode_q;
  glf_op_t    push_op, head_op;
  glf_qstat_t qstat;
  logic       push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SINGLE;
    end else if (text_mode_we_i) begin
      mode_q <= glf_mode_e'(text_mode_i);
    end
  end

  glf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .text_i  (text_i),
    .qstat_i (qstat),
    .push_o  (push),
    .op_o    (push_op)
  );

  glf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .stat_o (qstat)
  );

  glf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (head_op),
    .qstat_i (qstat),
    .pop_o   (pop),
    .glyph_o (glyph_o)
  );

endmodule

>>> verif/multibyte_text_glyph_locator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for multibyte_text_glyph_locator: drives text bytes through all four
// text modes and checks every glyph command beat against an in-bench glyph locator model.
// Depends on glf_pkg, glf_in_if, glf_out_if and the RTL top level.
module multibyte_text_glyph_locator_test
  import glf_pkg::*;
();

  typedef struct packed {
    logic        font_table;
    logic [19:0] offset;
    logic [13:0] x;
    logic [1:0]  stride;
    logic        last;
  } glyph_cmd_t;

  typedef enum logic [1:0] {
    RX_ALWAYS  = 2'd0,
    RX_RANDOM  = 2'd1,
    RX_PATTERN = 2'd2
  } rx_style_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       text_mode_we;
  logic [1:0] text_mode;

  glf_in_if  text_if();
  glf_out_if glyph_if();

  multibyte_text_glyph_locator i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .text_mode_we_i (text_mode_we),
    .text_mode_i    (text_mode),
    .text_i         (text_if),
    .glyph_o        (glyph_if)
  );

  // model state
  glf_mode_e   mode_q = MODE_SINGLE;
  logic [7:0]  lead_q = 8'd0;
  logic [13:0] pen_q  = 14'd0;
  glyph_cmd_t  pending_cmds[$];

  int        bytes_in;
  int        beats_checked;
  int        pairs_seen;
  int        mismatches;
  int        burst_left;
  int        gap_max;
  int        hold_left;
  int        rx_tick;
  rx_style_e rx_style = RX_RANDOM;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout, %0d commands still expected", pending_cmds.size());
    $display("FAIL");
    $finish;
  end

  function automatic void push_cmd(logic tbl, logic [31:0] off, logic [13:0] x,
                                   logic [1:0] stride, logic last);
    glyph_cmd_t c;
    c.font_table = tbl;
    c.offset     = off[19:0];
    c.x          = x;
    c.stride     = stride;
    c.last       = last;
    pending_cmds.push_back(c);
  endfunction

  function automatic void push_pair(logic [31:0] off, logic [31:0] step, logic [1:0] stride);
    push_cmd(1'b1, off, pen_q - HALF_WIDTH, stride, 1'b0);
    push_cmd(1'b1, off + step, pen_q, stride, 1'b1);
    pairs_seen++;
  endfunction

  // advance the locator model by one byte and queue the commands it causes
  function automatic void locate_glyphs(logic [7:0] b, logic first, logic [11:0] sx);
    logic [7:0]  lead;
    logic [31:0] bw, lw, k, t, base;
    lead = lead_q;
    bw   = {24'd0, b};
    lw   = {24'd0, lead};
    base = {12'd0, NATIONAL_BASE};
    if (first) pen_q = {2'b00, sx};
    case (mode_q)
      MODE_SINGLE: begin
        push_cmd(1'b0, bw * 32'd16, pen_q, STRIDE_NORMAL, 1'b1);
      end
      MODE_SJIS: begin
        if (lead == 8'd0) begin
          if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) lead_q = b;
          else push_cmd(1'b1, bw * 32'd16, pen_q, STRIDE_NORMAL, 1'b1);
        end else begin
          if (lead >= 8'h81 && lead <= 8'h9f) k = (lw - 32'h81) * 32'd2;
          else k = (lw - 32'he0) * 32'd2 + 32'd62;
          if (b >= 8'h40 && b <= 8'h7e) begin
            t = bw - 32'h40;
          end else if (b >= 8'h80 && b <= 8'h9e) begin
            t = bw - 32'h80 + 32'd63;
          end else begin
            t = bw - 32'h9f;
            k = k + 32'd1;
          end
          lead_q = 8'd0;
          push_pair(base + (k * 32'd94 + t) * 32'd32, {12'd0, STEP_NORMAL}, STRIDE_NORMAL);
        end
      end
      MODE_EUC: begin
        if (lead == 8'd0) begin
          if (b >= 8'h81 && b <= 8'hfe) lead_q = b;
          else push_cmd(1'b1, bw * 32'd16, pen_q, STRIDE_NORMAL, 1'b1);
        end else begin
          lead_q = 8'd0;
          push_pair(base + ((lw - 32'ha1) * 32'd94 + (bw - 32'ha1)) * 32'd32,
                    {12'd0, STEP_NORMAL}, STRIDE_NORMAL);
        end
      end
      default: begin
        if (lead == 8'd0) begin
          if (b >= 8'ha0) lead_q = b;
          else push_cmd(1'b0, bw * 32'd16, pen_q, STRIDE_NORMAL, 1'b1);
        end else begin
          lead_q = 8'd0;
          push_pair(((lw - 32'ha1) * 32'd94 + (bw - 32'ha1)) * 32'd32,
                    {12'd0, STEP_HALVES}, STRIDE_HALVES);
        end
      end
    endcase
    pen_q = pen_q + HALF_WIDTH;
  endfunction

  // receiver: long hold first, otherwise the current stall style
  initial begin
    glyph_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        glyph_if.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: glyph_if.ready <= 1'b1;
          RX_RANDOM: glyph_if.ready <= ($urandom_range(0, 9) < 6);
          default:   glyph_if.ready <= !((rx_tick % 5 == 0) || (rx_tick % 7 == 3));
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_beat
    glyph_cmd_t got, want;
    if (rst_n && glyph_if.valid && glyph_if.ready) begin
      got.font_table = glyph_if.font_table;
      got.offset     = glyph_if.glyph_offset;
      got.x          = glyph_if.draw_x;
      got.stride     = glyph_if.row_stride;
      got.last       = glyph_if.last_glyph;
      beats_checked++;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat tbl=%0d off=%05h x=%0d stride=%0d last=%0d",
                   $realtime, got.font_table, got.offset, $signed(got.x), got.stride, got.last);
      end else begin
        want = pending_cmds.pop_front();
        if (got.font_table !== want.font_table || got.offset !== want.offset ||
            got.x !== want.x || got.stride !== want.stride || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: beat mismatch exp tbl=%0d off=%05h x=%0d stride=%0d last=%0d",
                     $realtime, want.font_table, want.offset, $signed(want.x), want.stride,
                     want.last, " got tbl=%0d off=%05h x=%0d stride=%0d last=%0d",
                     got.font_table, got.offset, $signed(got.x), got.stride, got.last);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input logic [11:0] sx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        text_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    text_if.valid           <= 1'b1;
    text_if.code_byte       <= b;
    text_if.first_of_string <= first;
    text_if.start_x         <= sx;
    do @(posedge clk); while (!text_if.ready);
    locate_glyphs(b, first, sx);
    bytes_in++;
  endtask

  // lead bytes give no beat, so allow the pipeline to settle after the last one
  task automatic wait_idle();
    text_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input glf_mode_e m);
    wait_idle();
    text_mode_we <= 1'b1;
    text_mode    <= m;
    @(posedge clk);
    text_mode_we <= 1'b0;
    mode_q = m;
  endtask

  task automatic test_single_byte();
    set_mode(MODE_SINGLE);
    send_byte(8'h01, 1'b1, 12'd0);
    send_byte(8'hff, 1'b0, 12'd0);
    send_byte(8'h80, 1'b1, 12'hfff);
    send_byte(8'h7f, 1'b1, 12'haaa);
  endtask

  task automatic test_sjis();
    set_mode(MODE_SJIS);
    send_byte(8'h41, 1'b1, 12'd100);
    send_byte(8'ha5, 1'b0, 12'd0);
    send_byte(8'h81, 1'b0, 12'd0);
    send_byte(8'h40, 1'b0, 12'd0);
    send_byte(8'h9f, 1'b0, 12'd0);
    send_byte(8'hfc, 1'b0, 12'd0);
    send_byte(8'hfc, 1'b0, 12'd0);
    send_byte(8'h7f, 1'b0, 12'd0);
    // lead survives a new string; left half lands at x = -8
    send_byte(8'he0, 1'b0, 12'd0);
    send_byte(8'h80, 1'b1, 12'd0);
    send_byte(8'h9e, 1'b0, 12'd0);
  endtask

  task automatic test_euc();
    set_mode(MODE_EUC);
    send_byte(8'h80, 1'b1, 12'd555);
    send_byte(8'ha1, 1'b0, 12'd0);
    send_byte(8'ha1, 1'b0, 12'd0);
    send_byte(8'hfe, 1'b0, 12'd0);
    send_byte(8'hfe, 1'b0, 12'd0);
    send_byte(8'h81, 1'b0, 12'd0);
    send_byte(8'h01, 1'b0, 12'd0);
  endtask

  task automatic test_interleaved();
    set_mode(MODE_GB);
    send_byte(8'h9f, 1'b1, 12'd8);
    send_byte(8'ha0, 1'b0, 12'd0);
    send_byte(8'ha0, 1'b0, 12'd0);
    send_byte(8'hff, 1'b0, 12'd0);
    send_byte(8'hff, 1'b0, 12'd0);
  endtask

  task automatic test_lead_carry();
    send_byte(8'hc0, 1'b1, 12'd64);
    set_mode(MODE_SINGLE);
    send_byte(8'h20, 1'b0, 12'd0);
    set_mode(MODE_SJIS);
    send_byte(8'h45, 1'b0, 12'd0);
    send_byte(8'hea, 1'b0, 12'd0);
    set_mode(MODE_EUC);
    send_byte(8'hb0, 1'b0, 12'd0);
  endtask

  // mostly well-formed text for the current mode, some raw noise
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    logic       alt;
    int         r;
    r   = $urandom_range(0, 99);
    alt = 1'($urandom_range(0, 1));
    if (r < 12) begin
      b = 8'($urandom_range(1, 255));
    end else begin
      case (mode_q)
        MODE_SINGLE: b = 8'($urandom_range(1, 255));
        MODE_SJIS: begin
          if (lead_q != 8'd0)
            b = alt ? 8'($urandom_range(8'h40, 8'h7e)) : 8'($urandom_range(8'h80, 8'hfc));
          else if (r < 55)
            b = alt ? 8'($urandom_range(8'h81, 8'h9f)) : 8'($urandom_range(8'he0, 8'hfc));
          else
            b = alt ? 8'($urandom_range(8'h20, 8'h7e)) : 8'($urandom_range(8'ha1, 8'hdf));
        end
        MODE_EUC: begin
          if (lead_q != 8'd0 || r < 55) b = 8'($urandom_range(8'ha1, 8'hfe));
          else b = 8'($urandom_range(1, 8'h80));
        end
        default: begin
          if (lead_q != 8'd0) b = 8'($urandom_range(8'ha1, 8'hfe));
          else if (r < 55) b = 8'($urandom_range(8'ha1, 8'hf7));
          else b = 8'($urandom_range(1, 8'h9f));
        end
      endcase
    end
    return b;
  endfunction

  task automatic test_random();
    glf_mode_e   plan [7] = '{MODE_SINGLE, MODE_SJIS, MODE_EUC, MODE_GB,
                              MODE_SJIS, MODE_EUC, MODE_GB};
    logic        first;
    logic [11:0] sx;
    for (int p = 0; p < 7; p++) begin
      set_mode(plan[p]);
      gap_max  = (p == 0) ? 0 : $urandom_range(1, 6);
      rx_style = rx_style_e'(p % 3);
      for (int i = 0; i < 60; i++) begin
        // output held off while bytes keep coming: queue fills, input stalls
        if (p == 2 && i == 10) hold_left = 80;
        first = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) == 0) sx = $urandom_range(0, 1) ? 12'hfff : 12'd0;
        else sx = 12'($urandom_range(0, 4095));
        send_byte(pick_byte(), first, sx);
      end
    end
  endtask

  initial begin
    text_if.valid           <= 1'b0;
    text_if.code_byte       <= 8'd0;
    text_if.first_of_string <= 1'b0;
    text_if.start_x         <= 12'd0;
    text_mode_we            <= 1'b0;
    text_mode               <= MODE_SINGLE;
    gap_max = 2;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_byte();
    test_sjis();
    test_euc();
    test_interleaved();
    test_lead_carry();
    test_random();
    wait_idle();
    $display("sent %0d text bytes in all four modes, checked %0d command beats (%0d glyph pairs)",
             bytes_in, beats_checked, pairs_seen);
    $display("lead bytes carried over mode changes and string starts; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> multibyte_text_glyph_locator.f
rtl/core/glf_pkg.sv
rtl/core/glf_in_if.sv
rtl/core/glf_out_if.sv
rtl/core/glf_front.sv
rtl/core/glf_queue.sv
rtl/core/glf_back.sv
rtl/core/multibyte_text_glyph_locator.sv
verif/multibyte_text_glyph_locator_test.sv
